[rtl/ddalr_pkg.sv]
// ----------------------------------------------------------------------------
// ddalr_pkg
// Shared types and constants of the DDA line rasteriser.
// ----------------------------------------------------------------------------
package ddalr_pkg;

   localparam int COORD_W    = 12;   // input coordinate width
   localparam int PIXEL_W    = 13;   // signed output coordinate width
   localparam int FRAME_W    = 13;   // frame size register width
   localparam int SQ_W       = 24;   // square of one axis difference
   localparam int R2_W       = 25;   // sum of both squares
   localparam int STEP_W     = 19;   // unit step, Q2.16 signed
   localparam int POS_W      = 30;   // position, Q13.16 signed
   localparam int FRAC_W     = 16;

   // Shared shift/subtract unit
   localparam int SRC_W      = 34;   // bits still to be shifted in
   localparam int REM_W      = 26;   // partial remainder
   localparam int QUO_W      = 33;   // quotient or root
   localparam int ITER_W     = 6;
   localparam logic [ITER_W-1:0] ROOT_ITERS = 6'd13;  // root of the squared length
   localparam logic [ITER_W-1:0] DIV_ITERS  = 6'd33;  // squared axis over squared length
   localparam logic [ITER_W-1:0] UNIT_ITERS = 6'd17;  // root of that quotient

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = FRAME_W;
   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd1280;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd720;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic                start;
      arith_op_type        op;
      logic [SRC_W-1:0]    src;
      logic [REM_W-1:0]    rem;
      logic [R2_W-1:0]     divisor;
      logic [ITER_W-1:0]   iters;
   } arith_cmd_type;

   typedef struct packed {
      logic                done;
      logic [QUO_W-1:0]    quo;
      logic [REM_W-1:0]    rem;
   } arith_rsp_type;

   typedef struct packed {
      logic                       load;
      logic                       cut;
      logic [COORD_W-1:0]         start_x;
      logic [COORD_W-1:0]         start_y;
      logic signed [STEP_W-1:0]   step_x;
      logic signed [STEP_W-1:0]   step_y;
   } step_cmd_type;

endpackage

[rtl/ddalr_if.sv]
// ----------------------------------------------------------------------------
// ddalr_req_if / ddalr_rsp_if
// Valid/ready channels for line requests and pixel results.
// ----------------------------------------------------------------------------
interface ddalr_req_if import ddalr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ddalr_rsp_if import ddalr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PIXEL_W-1:0] pixel_x;
   logic signed [PIXEL_W-1:0] pixel_y;
   logic                      in_bounds;
   logic                      last_pixel;
   logic                      truncated;

   modport source (output valid, pixel_x, pixel_y, in_bounds, last_pixel, truncated,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, in_bounds, last_pixel, truncated,
                   output ready);
endinterface

[rtl/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasteriser: one line request in, one pixel beat per step out.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one line (start and end point) per beat. The block works
//   out the length as an exact integer square root, the unit step of each axis
//   as floor(|d| * 2^16 / length) through a division followed by a square
//   root, then walks ceil(length) steps, at most MAX_STEPS, on rsp_chan.
//   Every pixel beat carries the floored position, an in-frame flag, a last
//   marker and, on the last beat of a clipped line, the truncated flag.
//   A line of zero length produces no beat at all.
//   Setup of a line: the block squares and sums the differences, then runs the
//   shared shift/subtract unit for the length root, then for the division and
//   the root of each axis in turn, with a start and a hand-over around each
//   run, then loads the stepper, which takes the first step.
//   Pixels then leave at one per cycle while rsp_chan is ready. req_chan is
//   ready only while the sequencer is idle, which it is again once the line is
//   handed over, so a new line can be set up while the last one is stepping.
//   When rsp_chan stalls the result register holds, stepping pauses and a
//   finished setup waits until the stepper is free.
//   Reset is synchronous; it empties the block and restores the frame size
//   to 1280 x 720. csr_we writes frame_width (index 0) or frame_height
//   (index 1); write only while the block is idle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import ddalr_pkg::*; #(
   parameter int MAX_STEPS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   ddalr_req_if.sink             req_chan,
   ddalr_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CntW = $clog2(MAX_STEPS + 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SQUARE = 9'b000000010,
      ST_SUM    = 9'b000000100,
      ST_ROOT   = 9'b000001000,
      ST_DIVX   = 9'b000010000,
      ST_SQRTX  = 9'b000100000,
      ST_DIVY   = 9'b001000000,
      ST_SQRTY  = 9'b010000000,
      ST_LAUNCH = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      go_ff, go_in;
   logic [FRAME_W-1:0]        frame_w_ff, frame_w_in;
   logic [FRAME_W-1:0]        frame_h_ff, frame_h_in;
   logic [COORD_W-1:0]        start_x_ff, start_x_in;
   logic [COORD_W-1:0]        start_y_ff, start_y_in;
   logic                      neg_x_ff, neg_x_in;
   logic                      neg_y_ff, neg_y_in;
   logic [COORD_W-1:0]        mag_x_ff, mag_x_in;
   logic [COORD_W-1:0]        mag_y_ff, mag_y_in;
   logic [SQ_W-1:0]           sq_x_ff, sq_x_in;
   logic [SQ_W-1:0]           sq_y_ff, sq_y_in;
   logic [R2_W-1:0]           r2_ff, r2_in;
   logic [CntW-1:0]           count_ff, count_in;
   logic                      cut_ff, cut_in;
   logic signed [STEP_W-1:0]  step_x_ff, step_x_in;
   logic signed [STEP_W-1:0]  step_y_ff, step_y_in;

   logic                      accept;
   logic [COORD_W:0]          diff_x;
   logic [COORD_W:0]          diff_y;
   logic [PIXEL_W:0]          n_ext;
   logic                      n_cut;
   logic [STEP_W-1:0]         q_ext;
   logic [STEP_W-1:0]         q_neg;
   logic                      stepper_busy;
   arith_cmd_type             arith_cmd;
   arith_rsp_type             arith_rsp;
   step_cmd_type              step_cmd;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      diff_x = {1'b0, req_chan.end_x} - {1'b0, req_chan.start_x};
      diff_y = {1'b0, req_chan.end_y} - {1'b0, req_chan.start_y};
      // Number of steps is the root, plus one where the root is not exact.
      n_ext  = {1'b0, arith_rsp.quo[PIXEL_W-1:0]} + {{PIXEL_W{1'b0}}, (arith_rsp.rem != '0)};
      n_cut  = n_ext > (PIXEL_W + 1)'(MAX_STEPS);
      q_ext  = {2'b00, arith_rsp.quo[STEP_W-3:0]};
      q_neg  = STEP_W'(0) - q_ext;
   end

   // Operand selection for the shared unit
   always_comb begin
      arith_cmd         = '0;
      arith_cmd.op      = OP_DIV;
      arith_cmd.divisor = r2_ff;
      case (state_ff)
         ST_ROOT: begin
            arith_cmd.op    = OP_SQRT;
            arith_cmd.src   = {1'b0, r2_ff, 8'b0};
            arith_cmd.iters = ROOT_ITERS;
         end
         ST_DIVX: begin
            arith_cmd.src   = {sq_x_ff[0], {(SRC_W-1){1'b0}}};
            arith_cmd.rem   = {3'b000, sq_x_ff[SQ_W-1:1]};
            arith_cmd.iters = DIV_ITERS;
         end
         ST_DIVY: begin
            arith_cmd.src   = {sq_y_ff[0], {(SRC_W-1){1'b0}}};
            arith_cmd.rem   = {3'b000, sq_y_ff[SQ_W-1:1]};
            arith_cmd.iters = DIV_ITERS;
         end
         ST_SQRTX, ST_SQRTY: begin
            arith_cmd.op    = OP_SQRT;
            arith_cmd.src   = {1'b0, arith_rsp.quo};
            arith_cmd.iters = UNIT_ITERS;
         end
         default: begin
            arith_cmd.iters = '0;
         end
      endcase
      arith_cmd.start = go_ff && ((state_ff == ST_ROOT) || (state_ff == ST_DIVX) ||
                                  (state_ff == ST_SQRTX) || (state_ff == ST_DIVY) ||
                                  (state_ff == ST_SQRTY));
   end

   always_comb begin
      state_in   = state_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      mag_x_in   = mag_x_ff;
      mag_y_in   = mag_y_ff;
      sq_x_in    = sq_x_ff;
      sq_y_in    = sq_y_ff;
      r2_in      = r2_ff;
      count_in   = count_ff;
      cut_in     = cut_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      step_cmd         = '0;
      step_cmd.cut     = cut_ff;
      step_cmd.start_x = start_x_ff;
      step_cmd.start_y = start_y_ff;
      step_cmd.step_x  = step_x_ff;
      step_cmd.step_y  = step_y_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_w_in = csr_wdata;
            CSR_FRAME_HEIGHT: frame_h_in = csr_wdata;
            default:          frame_w_in = frame_w_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               start_x_in = req_chan.start_x;
               start_y_in = req_chan.start_y;
               neg_x_in   = diff_x[COORD_W];
               neg_y_in   = diff_y[COORD_W];
               mag_x_in   = diff_x[COORD_W] ? COORD_W'((COORD_W + 1)'(0) - diff_x)
                                            : diff_x[COORD_W-1:0];
               mag_y_in   = diff_y[COORD_W] ? COORD_W'((COORD_W + 1)'(0) - diff_y)
                                            : diff_y[COORD_W-1:0];
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_x_in  = mag_x_ff * mag_x_ff;
            sq_y_in  = mag_y_ff * mag_y_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            r2_in = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
            if (sq_x_ff == '0 && sq_y_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (arith_rsp.done) begin
               cut_in   = n_cut;
               count_in = n_cut ? CntW'(MAX_STEPS) : n_ext[CntW-1:0];
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (arith_rsp.done) begin
               state_in = ST_SQRTX;
            end
         end
         ST_SQRTX: begin
            if (arith_rsp.done) begin
               step_x_in = neg_x_ff ? q_neg : q_ext;
               state_in  = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (arith_rsp.done) begin
               state_in = ST_SQRTY;
            end
         end
         ST_SQRTY: begin
            if (arith_rsp.done) begin
               step_y_in = neg_y_ff ? q_neg : q_ext;
               state_in  = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            // Wait for the previous line to finish stepping before handing over.
            if (!stepper_busy) begin
               step_cmd.load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      go_in = (state_in != state_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         go_ff      <= 1'b0;
         frame_w_ff <= FRAME_WIDTH_RESET;
         frame_h_ff <= FRAME_HEIGHT_RESET;
      end else begin
         state_ff   <= state_in;
         go_ff      <= go_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
      r2_ff      <= r2_in;
      count_ff   <= count_in;
      cut_ff     <= cut_in;
      step_x_ff  <= step_x_in;
      step_y_ff  <= step_y_in;
   end

   ddalr_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   ddalr_stepper #(
      .MAX_STEPS (MAX_STEPS),
      .CntW      (CntW)
   ) u_stepper (
      .clock   (clock),
      .reset   (reset),
      .cmd     (step_cmd),
      .count   (count_ff),
      .frame_w (frame_w_ff),
      .frame_h (frame_h_ff),
      .busy    (stepper_busy),
      .rsp     (rsp_chan)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request channel still ready after a line was taken");

   a_done_in_arith_state: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == ST_ROOT) || (state_ff == ST_DIVX) ||
                         (state_ff == ST_SQRTX) || (state_ff == ST_DIVY) ||
                         (state_ff == ST_SQRTY))
      else $error("arith result arrived outside an arithmetic phase");

endmodule

[rtl/ddalr_arith.sv]
// ----------------------------------------------------------------------------
// ddalr_arith
// Shared shift/compare/subtract unit: restoring division or digit-by-digit
// square root, one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module ddalr_arith import ddalr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_cmd_type cmd,
   output arith_rsp_type rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   arith_op_type        op_ff, op_in;
   logic [SRC_W-1:0]    src_ff, src_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [R2_W-1:0]     div_ff, div_in;

   logic [REM_W-1:0]    shifted;
   logic [REM_W-1:0]    trial;
   logic [REM_W:0]      diff;
   logic                ge;

   // Division shifts in one dividend bit against the divisor; the root shifts
   // in two radicand bits against four times the root so far plus one.
   always_comb begin
      if (op_ff == OP_SQRT) begin
         shifted = {rem_ff[REM_W-3:0], src_ff[SRC_W-1 -: 2]};
         trial   = {quo_ff[REM_W-3:0], 2'b01};
      end else begin
         shifted = {rem_ff[REM_W-2:0], src_ff[SRC_W-1]};
         trial   = {1'b0, div_ff};
      end
      diff = {1'b0, shifted} - {1'b0, trial};
      ge   = ~diff[REM_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         op_in   = cmd.op;
         src_in  = cmd.src;
         rem_in  = cmd.rem;
         quo_in  = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_W-1:0] : shifted;
         quo_in = {quo_ff[QUO_W-2:0], ge};
         src_in = (op_ff == OP_SQRT) ? {src_ff[SRC_W-3:0], 2'b00} : {src_ff[SRC_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      src_ff <= src_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("arith unit restarted while busy");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("arith done without a finished run");

endmodule

[rtl/ddalr_stepper.sv]
// ----------------------------------------------------------------------------
// ddalr_stepper
// Position accumulator and result register: advances by the unit step once
// per beat and classifies each pixel against the frame.
// ----------------------------------------------------------------------------
module ddalr_stepper import ddalr_pkg::*; #(
   parameter int MAX_STEPS = 64,
   parameter int CntW      = $clog2(MAX_STEPS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  step_cmd_type       cmd,
   input  logic [CntW-1:0]    count,
   input  logic [FRAME_W-1:0] frame_w,
   input  logic [FRAME_W-1:0] frame_h,
   output logic               busy,
   ddalr_rsp_if.source        rsp
);

   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic signed [STEP_W-1:0]  step_x_ff, step_x_in;
   logic signed [STEP_W-1:0]  step_y_ff, step_y_in;
   logic [CntW-1:0]           left_ff, left_in;
   logic                      cut_ff, cut_in;
   logic                      valid_ff, valid_in;
   logic signed [PIXEL_W-1:0] pixel_x_ff, pixel_x_in;
   logic signed [PIXEL_W-1:0] pixel_y_ff, pixel_y_in;
   logic                      inb_ff, inb_in;
   logic                      last_ff, last_in;
   logic                      trunc_ff, trunc_in;

   logic signed [POS_W-1:0]   sum_x;
   logic signed [POS_W-1:0]   sum_y;
   logic                      adv;
   logic                      final_step;

   always_comb begin
      sum_x      = pos_x_ff + {{(POS_W-STEP_W){step_x_ff[STEP_W-1]}}, step_x_ff};
      sum_y      = pos_y_ff + {{(POS_W-STEP_W){step_y_ff[STEP_W-1]}}, step_y_ff};
      adv        = (left_ff != '0) && (!valid_ff || rsp.ready);
      final_step = (left_ff == CntW'(1));
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      left_in    = left_ff;
      cut_in     = cut_ff;
      valid_in   = valid_ff;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      inb_in     = inb_ff;
      last_in    = last_ff;
      trunc_in   = trunc_ff;
      if (valid_ff && rsp.ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         pos_x_in  = {2'b00, cmd.start_x, {FRAC_W{1'b0}}};
         pos_y_in  = {2'b00, cmd.start_y, {FRAC_W{1'b0}}};
         step_x_in = cmd.step_x;
         step_y_in = cmd.step_y;
         left_in   = count;
         cut_in    = cmd.cut;
      end else if (adv) begin
         pos_x_in   = sum_x;
         pos_y_in   = sum_y;
         left_in    = left_ff - 1'b1;
         valid_in   = 1'b1;
         // The integer bits of the two's complement position are its floor.
         pixel_x_in = sum_x[FRAC_W +: PIXEL_W];
         pixel_y_in = sum_y[FRAC_W +: PIXEL_W];
         inb_in     = !sum_x[POS_W-1] && (sum_x[FRAC_W +: FRAME_W] < frame_w) &&
                      !sum_y[POS_W-1] && (sum_y[FRAC_W +: FRAME_W] < frame_h);
         last_in    = final_step;
         trunc_in   = final_step && cut_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      step_x_ff  <= step_x_in;
      step_y_ff  <= step_y_in;
      cut_ff     <= cut_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      inb_ff     <= inb_in;
      last_ff    <= last_in;
      trunc_ff   <= trunc_in;
   end

   assign busy           = (left_ff != '0);
   assign rsp.valid      = valid_ff;
   assign rsp.pixel_x    = pixel_x_ff;
   assign rsp.pixel_y    = pixel_y_ff;
   assign rsp.in_bounds  = inb_ff;
   assign rsp.last_pixel = last_ff;
   assign rsp.truncated  = trunc_ff;

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> left_ff == '0)
      else $error("stepper loaded while a line is still running");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      left_ff <= CntW'(MAX_STEPS))
      else $error("step count above the limit");

endmodule

[sim/tb_dda_line_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking bench for the DDA line rasteriser. A short table of directed
// lines and frame sizes is run first, followed by phases of random lines under
// random frame sizes. Every accepted line is rasterised by a bench-side fixed
// point model and each pixel beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;
   import ddalr_pkg::*;

   localparam int     MAX_STEPS     = 64;
   localparam int     SETTLE_CYCLES = 200;
   localparam int     RANDOM_LINES  = 296;
   localparam longint CYCLE_LIMIT   = 6_000_000;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_x;
      logic signed [PIXEL_W-1:0] pixel_y;
      logic                      in_bounds;
      logic                      last_pixel;
      logic                      truncated;
   } pixel_beat_type;

   // One row of stimulus: either a frame size write or a line. A line with
   // known_count >= 0 has its pixel count and final beat typed in by hand.
   typedef struct {
      bit                  is_write;
      csr_index_type       reg_sel;
      logic [FRAME_W-1:0]  value;
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      int                  known_count;
      pixel_beat_type      known_last;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ddalr_req_if line_req();
   ddalr_rsp_if pixel_rsp();

   dda_line_rasterizer #(.MAX_STEPS(MAX_STEPS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (line_req),
      .rsp_chan  (pixel_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_beat_type     expected_pixels[$];
   logic [FRAME_W-1:0] frame_width_now  = FRAME_WIDTH_RESET;
   logic [FRAME_W-1:0] frame_height_now = FRAME_HEIGHT_RESET;
   int                 mismatches = 0;
   bit                 steady = 0;
   longint             cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_dda_line_rasterizer failed");
         $finish;
      end
   end

   // floor(sqrt(v)), bit by bit from the top
   function automatic int unsigned root_floor(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (longint'(trial) * longint'(trial) <= longint'(v))
            root = trial;
      end
      return root;
   endfunction

   // sign(d) * floor(|d| * 2^16 / sqrt(r2)), found without any real arithmetic
   function automatic int unit_step_of(int d, int unsigned r2);
      longint unsigned mag;
      longint unsigned num;
      longint unsigned trial;
      longint unsigned q;
      mag = (d < 0) ? -d : d;
      num = (mag * mag) << 32;
      q = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = q | (64'd1 << b);
         if (trial <= 65536 && trial * trial * r2 <= num)
            q = trial;
      end
      return (d < 0) ? -int'(q) : int'(q);
   endfunction

   task automatic rasterise_line(input logic [COORD_W-1:0] sx, sy, ex, ey,
                                 ref pixel_beat_type beats[$]);
      int             dx, dy, n, step_x, step_y, pos_x, pos_y, px, py;
      int unsigned    r2, root;
      bit             cut;
      pixel_beat_type beat;
      beats.delete();
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      r2 = dx * dx + dy * dy;
      if (r2 == 0)
         return;
      root = root_floor(r2);
      n = (root * root == r2) ? root : root + 1;
      cut = n > MAX_STEPS;
      if (cut)
         n = MAX_STEPS;
      step_x = unit_step_of(dx, r2);
      step_y = unit_step_of(dy, r2);
      pos_x = int'(sx) << FRAC_W;
      pos_y = int'(sy) << FRAC_W;
      for (int k = 1; k <= n; k++) begin
         pos_x += step_x;
         pos_y += step_y;
         // Arithmetic shift of the Q.16 position is the floor, also below zero.
         px = pos_x >>> FRAC_W;
         py = pos_y >>> FRAC_W;
         beat.pixel_x    = px[PIXEL_W-1:0];
         beat.pixel_y    = py[PIXEL_W-1:0];
         beat.in_bounds  = px >= 0 && px < int'(frame_width_now) &&
                           py >= 0 && py < int'(frame_height_now);
         beat.last_pixel = (k == n);
         beat.truncated  = (k == n) && cut;
         beats.push_back(beat);
      end
   endtask

   function automatic plan_row_type line_row(int sx, int sy, int ex, int ey,
                                             int count = -1, int lx = 0, int ly = 0,
                                             bit inb = 0, bit cut = 0);
      plan_row_type row;
      row.is_write    = 1'b0;
      row.reg_sel     = CSR_FRAME_WIDTH;
      row.value       = '0;
      row.start_x     = sx[COORD_W-1:0];
      row.start_y     = sy[COORD_W-1:0];
      row.end_x       = ex[COORD_W-1:0];
      row.end_y       = ey[COORD_W-1:0];
      row.known_count = count;
      row.known_last.pixel_x    = lx[PIXEL_W-1:0];
      row.known_last.pixel_y    = ly[PIXEL_W-1:0];
      row.known_last.in_bounds  = inb;
      row.known_last.last_pixel = 1'b1;
      row.known_last.truncated  = cut;
      return row;
   endfunction

   function automatic plan_row_type csr_row(csr_index_type sel, int value);
      plan_row_type row;
      row = line_row(0, 0, 0, 0);
      row.is_write = 1'b1;
      row.reg_sel  = sel;
      row.value    = value[FRAME_W-1:0];
      return row;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 15);
      return $urandom_range(30, 60);
   endfunction

   function automatic int pick_frame_size();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 8191;
         2: return 4096;
         3: return 1;
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return 4095;
      return $urandom_range(0, 4095);
   endfunction

   task automatic wait_drained();
      line_req.valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_line(input logic [COORD_W-1:0] sx, sy, ex, ey);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
      if (gap > 0) begin
         line_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      line_req.valid   <= 1'b1;
      line_req.start_x <= sx;
      line_req.start_y <= sy;
      line_req.end_x   <= ex;
      line_req.end_y   <= ey;
      do
         @(posedge clock);
      while (!line_req.ready);
   endtask

   task automatic run_plan_row(input plan_row_type row);
      pixel_beat_type beats[$];
      if (row.is_write) begin
         // A zero-length line leaves no beat behind, so allow the setup time too.
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= row.reg_sel;
         csr_wdata <= row.value;
         @(posedge clock);
         csr_we <= 1'b0;
         if (row.reg_sel == CSR_FRAME_WIDTH)
            frame_width_now = row.value;
         else
            frame_height_now = row.value;
         @(posedge clock);
      end else begin
         send_line(row.start_x, row.start_y, row.end_x, row.end_y);
         rasterise_line(row.start_x, row.start_y, row.end_x, row.end_y, beats);
         if (row.known_count < 0) begin
            foreach (beats[i])
               expected_pixels.push_back(beats[i]);
         end else begin
            for (int i = 0; i < row.known_count - 1 && i < beats.size(); i++)
               expected_pixels.push_back(beats[i]);
            if (row.known_count > 0)
               expected_pixels.push_back(row.known_last);
         end
      end
   endtask

   // Result side: check each accepted beat and, outside steady phases, stall at random.
   initial begin
      int             hold;
      pixel_beat_type want;
      hold = 0;
      pixel_rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (pixel_rsp.valid && pixel_rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel beat with nothing expected: x %0d, y %0d",
                      pixel_rsp.pixel_x, pixel_rsp.pixel_y);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (pixel_rsp.pixel_x !== want.pixel_x) begin
                  $error("pixel_x: expected %0d, got %0d", want.pixel_x, pixel_rsp.pixel_x);
                  mismatches++;
               end
               if (pixel_rsp.pixel_y !== want.pixel_y) begin
                  $error("pixel_y: expected %0d, got %0d", want.pixel_y, pixel_rsp.pixel_y);
                  mismatches++;
               end
               if (pixel_rsp.in_bounds !== want.in_bounds) begin
                  $error("in_bounds: expected %0b, got %0b",
                         want.in_bounds, pixel_rsp.in_bounds);
                  mismatches++;
               end
               if (pixel_rsp.last_pixel !== want.last_pixel) begin
                  $error("last_pixel: expected %0b, got %0b",
                         want.last_pixel, pixel_rsp.last_pixel);
                  mismatches++;
               end
               if (pixel_rsp.truncated !== want.truncated) begin
                  $error("truncated: expected %0b, got %0b",
                         want.truncated, pixel_rsp.truncated);
                  mismatches++;
               end
            end
         end
         if (steady) begin
            pixel_rsp.ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 9) < 6) begin
            pixel_rsp.ready <= 1'b1;
            hold = $urandom_range(0, 19);
         end else begin
            pixel_rsp.ready <= 1'b0;
            hold = pick_pause() - 1;
         end
      end
   end

   // Request side: directed table, then random phases.
   initial begin
      plan_row_type plan[$];
      int           sent, phase_len, kind, span, sx, sy, ex, ey;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      line_req.valid   = 1'b0;
      line_req.start_x = '0;
      line_req.start_y = '0;
      line_req.end_x   = '0;
      line_req.end_y   = '0;

      // Reset frame of 1280 x 720.
      plan.push_back(line_row(0, 0, 0, 0, 0));
      plan.push_back(line_row(4095, 4095, 4095, 4095, 0));
      plan.push_back(line_row(0, 0, 3, 0, 3, 3, 0, 1, 0));
      plan.push_back(line_row(0, 0, 0, 3, 3, 0, 3, 1, 0));
      plan.push_back(line_row(10, 10, 7, 10, 3, 7, 10, 1, 0));
      plan.push_back(line_row(10, 10, 10, 7, 3, 10, 7, 1, 0));
      plan.push_back(line_row(0, 0, 100, 0, 64, 64, 0, 1, 1));
      plan.push_back(line_row(4095, 4095, 0, 4095, 64, 4031, 4095, 0, 1));
      plan.push_back(line_row(0, 4095, 0, 0, 64, 0, 4031, 0, 1));
      plan.push_back(line_row(0, 0, 4095, 4095));
      plan.push_back(line_row(4095, 0, 0, 4095));
      plan.push_back(line_row(1279, 719, 1279, 716, 3, 1279, 716, 1, 0));
      plan.push_back(line_row(1279, 0, 1282, 0, 3, 1282, 0, 0, 0));
      plan.push_back(line_row(0, 719, 0, 722, 3, 0, 722, 0, 0));
      plan.push_back(line_row(3, 4, 0, 0));
      // Overshoots the origin by a fraction, so the last pixel floors to -1.
      plan.push_back(line_row(1, 1, 0, 0));
      plan.push_back(line_row(0, 0, 64, 0, 64, 64, 0, 1, 0));
      plan.push_back(line_row(0, 0, 65, 0, 64, 64, 0, 1, 1));
      plan.push_back(csr_row(CSR_FRAME_WIDTH, 0));
      plan.push_back(line_row(0, 0, 2, 0, 2, 2, 0, 0, 0));
      plan.push_back(csr_row(CSR_FRAME_WIDTH, 4096));
      plan.push_back(csr_row(CSR_FRAME_HEIGHT, 4096));
      plan.push_back(line_row(4092, 4095, 4095, 4095, 3, 4095, 4095, 1, 0));
      plan.push_back(csr_row(CSR_FRAME_WIDTH, 8191));
      plan.push_back(csr_row(CSR_FRAME_HEIGHT, 8191));
      plan.push_back(line_row(2000, 3000, 2030, 3040));
      plan.push_back(csr_row(CSR_FRAME_WIDTH, 1));
      plan.push_back(csr_row(CSR_FRAME_HEIGHT, 1));
      plan.push_back(line_row(1, 0, 0, 0, 1, 0, 0, 1, 0));
      plan.push_back(line_row(0, 0, 0, 1, 1, 0, 1, 0, 0));
      plan.push_back(csr_row(CSR_FRAME_HEIGHT, 0));
      plan.push_back(line_row(1, 0, 0, 0, 1, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         run_plan_row(plan[i]);

      sent = 0;
      while (sent < RANDOM_LINES) begin
         run_plan_row(csr_row(CSR_FRAME_WIDTH, pick_frame_size()));
         run_plan_row(csr_row(CSR_FRAME_HEIGHT, pick_frame_size()));
         steady    = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 50);
         if (phase_len > RANDOM_LINES - sent)
            phase_len = RANDOM_LINES - sent;
         repeat (phase_len) begin
            if ($urandom_range(0, 39) == 0)
               wait_drained();
            kind = $urandom_range(0, 99);
            sx = pick_coord();
            sy = pick_coord();
            if (kind < 5) begin
               ex = sx;
               ey = sy;
            end else if (kind < 90) begin
               // Mostly short lines; the wider span also crosses the step limit.
               span = (kind < 75) ? 20 : 70;
               ex = sx + int'($urandom_range(0, 2 * span)) - span;
               ey = sy + int'($urandom_range(0, 2 * span)) - span;
               ex = (ex < 0) ? 0 : (ex > 4095) ? 4095 : ex;
               ey = (ey < 0) ? 0 : (ey > 4095) ? 4095 : ey;
            end else begin
               ex = $urandom_range(0, 4095);
               ey = $urandom_range(0, 4095);
            end
            run_plan_row(line_row(sx, sy, ex, ey));
            sent++;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_dda_line_rasterizer passed");
      else
         $display("tb_dda_line_rasterizer failed");
      $finish;
   end

endmodule
